[hw/rtl/nctc_pkg.sv]
// ----------------------------------------------------------------------------
// nctc_pkg
// Shared types and constants of the nested comment trivia classifier.
// ----------------------------------------------------------------------------
package nctc_pkg;

   localparam int MAX_NESTING = 255;
   localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // Number of buffered results in the response queue.
   localparam int QUEUE_DEPTH = 3;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_trivia;
      logic       end_of_text;
      logic       unterminated;
      logic       last_of_run;
   } result_type;

   // Results produced by one accepted byte: zero, one or two.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

endpackage

[hw/rtl/nctc_step.sv]
// ----------------------------------------------------------------------------
// nctc_step
// Scanner state registers and the per-byte classification logic.
// ----------------------------------------------------------------------------
module nctc_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            text_byte,
   input  logic                  final_byte,
   output nctc_pkg::step_out_type step_out
);

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_SLASH = 2'd1,
      PEND_STAR  = 2'd2
   } pend_type;

   mode_type                      mode_ff, mode_in;
   pend_type                      pend_ff, pend_in;
   logic                          held_ff, held_in;
   logic [nctc_pkg::DEPTH_W-1:0]  depth_ff, depth_in;

   nctc_pkg::result_type          res0, res1;
   logic [1:0]                    cnt;
   logic                          plain;
   logic                          is_space;
   logic                          unterm;

   assign is_space = (text_byte == nctc_pkg::CH_SPACE) || (text_byte == nctc_pkg::CH_TAB) ||
                     (text_byte == nctc_pkg::CH_CR) || (text_byte == nctc_pkg::CH_LF);

   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      held_in  = held_ff;
      depth_in = depth_ff;
      res0     = '0;
      res1     = '0;
      cnt      = 2'd0;
      plain    = 1'b1;
      unterm   = 1'b0;

      case (mode_ff)
         MODE_LINE: begin
            res0 = '{text_byte, 1'b1, 1'b0, 1'b0, 1'b0};
            cnt  = 2'd1;
            if (text_byte == nctc_pkg::CH_LF) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            res0 = '{text_byte, 1'b1, 1'b0, 1'b0, 1'b0};
            cnt  = 2'd1;
            if (pend_ff == PEND_SLASH && text_byte == nctc_pkg::CH_STAR) begin
               if (depth_ff != nctc_pkg::DEPTH_W'(nctc_pkg::MAX_NESTING)) begin
                  depth_in = depth_ff + 1'b1;
               end
               pend_in = PEND_NONE;
            end else if (pend_ff == PEND_STAR && text_byte == nctc_pkg::CH_SLASH) begin
               if (depth_ff != '0) begin
                  depth_in = depth_ff - 1'b1;
               end
               pend_in = PEND_NONE;
               if (depth_in == '0) begin
                  mode_in = MODE_NORMAL;
               end
            end else if (text_byte == nctc_pkg::CH_SLASH) begin
               pend_in = PEND_SLASH;
            end else if (text_byte == nctc_pkg::CH_STAR) begin
               pend_in = PEND_STAR;
            end else begin
               pend_in = PEND_NONE;
            end
         end
         default: begin
            if (held_ff) begin
               held_in = 1'b0;
               if (text_byte == nctc_pkg::CH_SLASH) begin
                  res0    = '{nctc_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0, 1'b0};
                  res1    = '{text_byte, 1'b1, 1'b0, 1'b0, 1'b0};
                  cnt     = 2'd2;
                  mode_in = MODE_LINE;
                  plain   = 1'b0;
               end else if (text_byte == nctc_pkg::CH_STAR) begin
                  res0     = '{nctc_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0, 1'b0};
                  res1     = '{text_byte, 1'b1, 1'b0, 1'b0, 1'b0};
                  cnt      = 2'd2;
                  mode_in  = MODE_BLOCK;
                  depth_in = nctc_pkg::DEPTH_W'(1);
                  pend_in  = PEND_NONE;
                  plain    = 1'b0;
               end else begin
                  res0 = '{nctc_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0, 1'b0};
                  cnt  = 2'd1;
               end
            end
            if (plain) begin
               if (text_byte == nctc_pkg::CH_SLASH && !final_byte && !is_space) begin
                  held_in = 1'b1;
               end else if (cnt == 2'd0) begin
                  res0 = '{text_byte, is_space, 1'b0, 1'b0, 1'b0};
                  cnt  = 2'd1;
               end else begin
                  res1 = '{text_byte, is_space, 1'b0, 1'b0, 1'b0};
                  cnt  = 2'd2;
               end
            end
         end
      endcase

      // The last result of the step carries the run and end-of-text marks.
      unterm = final_byte && (mode_in == MODE_BLOCK);
      if (cnt == 2'd1) begin
         res0.last_of_run  = 1'b1;
         res0.end_of_text  = final_byte;
         res0.unterminated = unterm;
      end else if (cnt == 2'd2) begin
         res1.last_of_run  = 1'b1;
         res1.end_of_text  = final_byte;
         res1.unterminated = unterm;
      end

      // The final byte ends the text, and the next byte starts a fresh one.
      if (final_byte) begin
         mode_in  = MODE_NORMAL;
         pend_in  = PEND_NONE;
         held_in  = 1'b0;
         depth_in = '0;
      end
   end

   assign step_out = '{cnt, res0, res1};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         pend_ff  <= PEND_NONE;
         held_ff  <= 1'b0;
         depth_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         held_ff  <= held_in;
         depth_ff <= depth_in;
      end
   end

`ifndef SYNTHESIS
   a_block_has_depth: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_BLOCK |-> depth_ff != '0)
      else $error("block comment open with zero nesting depth");
   a_held_only_normal: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> mode_ff == MODE_NORMAL)
      else $error("slash held outside normal mode");
   a_pend_only_block: assert property (@(posedge clock) disable iff (reset)
      pend_ff != PEND_NONE |-> mode_ff == MODE_BLOCK)
      else $error("block pending marker set outside block comment");
`endif

endmodule

[hw/rtl/nctc_rsp_queue.sv]
// ----------------------------------------------------------------------------
// nctc_rsp_queue
// Three-entry result queue; takes up to two results per cycle while it has room, emits one.
// ----------------------------------------------------------------------------
module nctc_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nctc_pkg::step_out_type step_out,
   input  logic                   pop_ready,
   output logic                   out_valid,
   output nctc_pkg::result_type   out_item,
   output logic                   can_accept
);

   nctc_pkg::result_type                     slot_ff [nctc_pkg::QUEUE_DEPTH];
   nctc_pkg::result_type                     slot_in [nctc_pkg::QUEUE_DEPTH];
   logic [nctc_pkg::QCNT_W-1:0]              count_ff, count_in;
   logic [nctc_pkg::QCNT_W-1:0]              base;
   logic [1:0]                               add;
   logic                                     pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[0];
   assign pop       = out_valid && pop_ready;

   // Room for two more results after this cycle's pop.
   assign can_accept = (count_ff <= nctc_pkg::QCNT_W'(nctc_pkg::QUEUE_DEPTH - 2))
                    || (pop && count_ff <= nctc_pkg::QCNT_W'(nctc_pkg::QUEUE_DEPTH - 1));

   assign base     = count_ff - nctc_pkg::QCNT_W'(pop);
   assign add      = push ? step_out.count : 2'd0;
   assign count_in = base + nctc_pkg::QCNT_W'(add);

   always_comb begin
      for (int i = 0; i < nctc_pkg::QUEUE_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < nctc_pkg::QUEUE_DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
      for (int i = 0; i < nctc_pkg::QUEUE_DEPTH; i++) begin
         if (add != 2'd0 && base == nctc_pkg::QCNT_W'(i)) begin
            slot_in[i] = step_out.first;
         end
         if (add == 2'd2 && base + 1'b1 == nctc_pkg::QCNT_W'(i)) begin
            slot_in[i] = step_out.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < nctc_pkg::QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nctc_pkg::QCNT_W'(nctc_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> can_accept)
      else $error("byte accepted without room for its results");
`endif

endmodule

[hw/rtl/nested_comment_trivia_classifier.sv]
// ----------------------------------------------------------------------------
// nested_comment_trivia_classifier
// Labels each source byte as trivia (whitespace, line or nested block
// comment) or token byte.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while req_tready is high, and its results
// are registered into a three-entry result queue when it is accepted. A
// byte yields zero, one or two results; a '/' in normal text is held until
// the next byte and then comes out with it. The output side moves one result
// per cycle while rsp_tready is high, so a byte that yields two results takes
// two output slots; the queue keeps accepting while up to one result waits, or two with one leaving.
// The scanner state returns to reset after the byte marked by req_tlast.
// ----------------------------------------------------------------------------
module nested_comment_trivia_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] is_trivia, [1] end_of_text, [2] unterminated
   output logic       rsp_tlast    // last_of_run
);

   nctc_pkg::step_out_type step_out;
   nctc_pkg::result_type   head;
   logic                   accept;

   assign accept = req_tvalid && req_tready;

   nctc_step u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_tdata),
      .final_byte (req_tlast),
      .step_out   (step_out)
   );

   nctc_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .step_out   (step_out),
      .pop_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_item   (head),
      .can_accept (req_tready)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.unterminated, head.end_of_text, head.is_trivia};
   assign rsp_tlast = head.last_of_run;

`ifndef SYNTHESIS
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("end of text on a result that is not last of its run");
   a_unterm_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1])
      else $error("unterminated flag without end of text");
   a_unterm_trivia: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[0])
      else $error("unterminated comment ends on a token byte");
`endif

endmodule

[verif/tb_nested_comment_trivia_classifier.sv]
// ----------------------------------------------------------------------------
// tb_nested_comment_trivia_classifier
// Self-checking testbench for the nested comment trivia classifier.
// ----------------------------------------------------------------------------
// Source texts are streamed in as requests, each text closed by req_tlast. A
// scoreboard keeps its own copy of the scanner state, works out the labelled
// bytes that each accepted request should produce and checks every result in
// order. A short directed set is followed by random texts built from tokens,
// whitespace, line comments, nested block comments and noise, including one
// text that nests past the depth limit. The sender idles at random in two of
// four phases and the receiver in two, and the receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_nested_comment_trivia_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 100;
   localparam int DEEP_OPENERS = 256;
   localparam int MAX_PRINTED = 30;

   typedef enum logic [1:0] {
      SCAN_NORMAL = 2'd0,
      SCAN_LINE   = 2'd1,
      SCAN_BLOCK  = 2'd2
   } scan_mode_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_SLASH = 2'd1,
      PEND_STAR  = 2'd2
   } block_pend_type;

   typedef struct packed {
      logic [7:0] text;
      logic       fin;
   } text_req_type;

   // Scanner state mirror plus the queue of labelled bytes still owed.
   class trivia_scoreboard;
      scan_mode_type        mode;
      logic                 held;
      block_pend_type       pend;
      int unsigned          depth;
      nctc_pkg::result_type expected_q[$];
      int unsigned          errors;
      int unsigned          checked;

      function new();
         errors  = 0;
         checked = 0;
         restart();
      endfunction

      function void restart();
         mode  = SCAN_NORMAL;
         held  = 1'b0;
         pend  = PEND_NONE;
         depth = 0;
      endfunction

      function nctc_pkg::result_type make_result(logic [7:0] b, logic trivia);
         nctc_pkg::result_type r;
         r.out_byte     = b;
         r.is_trivia    = trivia;
         r.end_of_text  = 1'b0;
         r.unterminated = 1'b0;
         r.last_of_run  = 1'b0;
         return r;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [7:0] b, logic fin);
         nctc_pkg::result_type produced[$];
         logic plain;
         int   last;
         plain = 1'b1;
         case (mode)
            SCAN_LINE: begin
               produced.push_back(make_result(b, 1'b1));
               if (b == nctc_pkg::CH_LF) mode = SCAN_NORMAL;
            end
            SCAN_BLOCK: begin
               produced.push_back(make_result(b, 1'b1));
               if (pend == PEND_SLASH && b == nctc_pkg::CH_STAR) begin
                  if (depth < nctc_pkg::MAX_NESTING) depth++;
                  pend = PEND_NONE;
               end else if (pend == PEND_STAR && b == nctc_pkg::CH_SLASH) begin
                  if (depth > 0) depth--;
                  pend = PEND_NONE;
                  if (depth == 0) mode = SCAN_NORMAL;
               end else begin
                  pend = (b == nctc_pkg::CH_SLASH) ? PEND_SLASH :
                         (b == nctc_pkg::CH_STAR)  ? PEND_STAR  : PEND_NONE;
               end
            end
            default: begin
               if (held) begin
                  held = 1'b0;
                  if (b == nctc_pkg::CH_SLASH || b == nctc_pkg::CH_STAR) begin
                     produced.push_back(make_result(nctc_pkg::CH_SLASH, 1'b1));
                     produced.push_back(make_result(b, 1'b1));
                     plain = 1'b0;
                     if (b == nctc_pkg::CH_SLASH) begin
                        mode = SCAN_LINE;
                     end else begin
                        mode  = SCAN_BLOCK;
                        depth = 1;
                        pend  = PEND_NONE;
                     end
                  end else begin
                     produced.push_back(make_result(nctc_pkg::CH_SLASH, 1'b0));
                  end
               end
               if (plain) begin
                  if (b inside {nctc_pkg::CH_SPACE, nctc_pkg::CH_TAB,
                                nctc_pkg::CH_CR, nctc_pkg::CH_LF})
                     produced.push_back(make_result(b, 1'b1));
                  else if (b == nctc_pkg::CH_SLASH && !fin)
                     held = 1'b1;
                  else
                     produced.push_back(make_result(b, 1'b0));
               end
            end
         endcase
         if (produced.size() > 0) begin
            last = produced.size() - 1;
            produced[last].last_of_run = 1'b1;
            if (fin) begin
               produced[last].end_of_text  = 1'b1;
               produced[last].unterminated = (mode == SCAN_BLOCK);
            end
         end
         foreach (produced[i]) expected_q.push_back(produced[i]);
         if (fin) restart();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_response(nctc_pkg::result_type got);
         nctc_pkg::result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d (byte %h) arrived with nothing expected",
                             checked, got.out_byte));
            return;
         end
         want = expected_q.pop_front();
         if (got.out_byte !== want.out_byte)
            report($sformatf("result %0d out_byte %h, want %h",
                             checked, got.out_byte, want.out_byte));
         if (got.is_trivia !== want.is_trivia)
            report($sformatf("result %0d is_trivia %b, want %b",
                             checked, got.is_trivia, want.is_trivia));
         if (got.end_of_text !== want.end_of_text)
            report($sformatf("result %0d end_of_text %b, want %b",
                             checked, got.end_of_text, want.end_of_text));
         if (got.unterminated !== want.unterminated)
            report($sformatf("result %0d unterminated %b, want %b",
                             checked, got.unterminated, want.unterminated));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("result %0d last_of_run %b, want %b",
                             checked, got.last_of_run, want.last_of_run));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   trivia_scoreboard sb = new();

   logic [7:0]    text_buf[$];
   text_req_type  stim_q[$];
   int            stall_pct;
   int            hold_cycles;
   int            cycle_count;

   nested_comment_trivia_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5ns clock = ~clock;

   // ---------------------------------------------------------------------
   // Text construction
   // ---------------------------------------------------------------------
   function automatic void push_str(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   // Moves the text under construction into the request queue.
   function automatic void close_text();
      text_req_type r;
      foreach (text_buf[i]) begin
         r.text = text_buf[i];
         r.fin  = (i == text_buf.size() - 1);
         stim_q.push_back(r);
      end
      text_buf.delete();
   endfunction

   function automatic logic [7:0] rand_other();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == nctc_pkg::CH_SLASH || b == nctc_pkg::CH_STAR);
      return b;
   endfunction

   function automatic logic [7:0] rand_token();
      logic [7:0] b;
      do b = rand_other();
      while (b inside {nctc_pkg::CH_SPACE, nctc_pkg::CH_TAB, nctc_pkg::CH_CR,
                       nctc_pkg::CH_LF});
      return b;
   endfunction

   function automatic logic [7:0] rand_space();
      case ($urandom_range(3))
         0: return nctc_pkg::CH_SPACE;
         1: return nctc_pkg::CH_TAB;
         2: return nctc_pkg::CH_CR;
         default: return nctc_pkg::CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] rand_noise();
      case ($urandom_range(5))
         0: return nctc_pkg::CH_SLASH;
         1: return nctc_pkg::CH_STAR;
         2: return nctc_pkg::CH_LF;
         3: return nctc_pkg::CH_SPACE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void add_block(int level);
      text_buf.push_back(nctc_pkg::CH_SLASH);
      text_buf.push_back(nctc_pkg::CH_STAR);
      repeat ($urandom_range(5)) begin
         if (level < 3 && $urandom_range(3) == 0) begin
            add_block(level + 1);
         end else begin
            // A lone star or slash followed by plain text must not close or open.
            if ($urandom_range(4) == 0)
               text_buf.push_back($urandom_range(1) ? nctc_pkg::CH_STAR
                                                    : nctc_pkg::CH_SLASH);
            text_buf.push_back(rand_other());
         end
      end
      text_buf.push_back(nctc_pkg::CH_STAR);
      text_buf.push_back(nctc_pkg::CH_SLASH);
   endfunction

   function automatic void add_piece();
      logic [7:0] b;
      case ($urandom_range(6))
         0: repeat ($urandom_range(1, 4)) text_buf.push_back(rand_token());
         1: repeat ($urandom_range(1, 3)) text_buf.push_back(rand_space());
         2: begin
            push_str("//");
            repeat ($urandom_range(6)) begin
               do b = 8'($urandom_range(255)); while (b == nctc_pkg::CH_LF);
               text_buf.push_back(b);
            end
            text_buf.push_back(nctc_pkg::CH_LF);
         end
         3: add_block(0);
         4: push_str("*/");
         5: begin
            text_buf.push_back(nctc_pkg::CH_SLASH);
            text_buf.push_back($urandom_range(1) ? rand_token() : rand_space());
         end
         default: text_buf.push_back(rand_noise());
      endcase
   endfunction

   function automatic void add_random_text();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 20)) text_buf.push_back(rand_noise());
      end else begin
         repeat ($urandom_range(1, 10)) add_piece();
         // Cutting the text short leaves comments open at the final byte.
         if ($urandom_range(99) < 15 && text_buf.size() > 1)
            repeat ($urandom_range(1, text_buf.size() - 1)) void'(text_buf.pop_back());
      end
      close_text();
   endfunction

   // Nests past the depth limit, so the closers end the comment early.
   function automatic void add_deep_text();
      repeat (DEEP_OPENERS) push_str("/*");
      text_buf.push_back(rand_token());
      repeat (DEEP_OPENERS) push_str("*/");
      text_buf.push_back(rand_token());
      close_text();
   endfunction

   function automatic void add_directed_texts();
      text_buf.push_back(8'h00);
      text_buf.push_back(nctc_pkg::CH_SPACE);
      text_buf.push_back(nctc_pkg::CH_TAB);
      text_buf.push_back(8'hFF);
      close_text();
      // A slash as the final byte is emitted at once.
      push_str("/");
      close_text();
      // A held slash and the final byte come out together.
      push_str("/b");
      close_text();
      // A stray closer in normal text is two token bytes.
      push_str("*/");
      text_buf.push_back(nctc_pkg::CH_CR);
      text_buf.push_back(nctc_pkg::CH_LF);
      close_text();
      push_str("//x");
      text_buf.push_back(nctc_pkg::CH_LF);
      close_text();
      push_str("/*/**/*/");
      close_text();
      // Ends inside a block comment.
      push_str("/*x");
      close_text();
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Entered and left at a falling edge; tvalid stays high after the last
   // request so that a following call can present its first one at once.
   task automatic drive_requests(int gap_pct);
      text_req_type item;
      while (stim_q.size() > 0) begin
         item = stim_q.pop_front();
         while ($urandom_range(99) < gap_pct) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= item.text;
         req_tlast  <= item.fin;
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
      end
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response('{out_byte: rsp_tdata, is_trivia: rsp_tuser[0],
                                end_of_text: rsp_tuser[1],
                                unterminated: rsp_tuser[2],
                                last_of_run: rsp_tlast});
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata, req_tlast);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      int gap_pct[4];
      int stall_of[4];
      gap_pct  = '{0, 60, 0, 21};
      stall_of = '{0, 0, 60, 21};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      stall_pct   = 0;
      hold_cycles = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      add_directed_texts();
      for (int p = 0; p < 4; p++) begin
         stall_pct = stall_of[p];
         if (p == 0) hold_cycles = 300;
         if (p == 1) add_deep_text();
         while (stim_q.size() < PHASE_ITEMS) add_random_text();
         drive_requests(gap_pct[p]);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));

      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/nctc_pkg.sv
hw/rtl/nctc_step.sv
hw/rtl/nctc_rsp_queue.sv
hw/rtl/nested_comment_trivia_classifier.sv
verif/tb_nested_comment_trivia_classifier.sv
